/* rtl/core/gbsl_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the glyph lookup engine.
// Used by the register block, controller, datapath and top level; depends on nothing.
package gbsl_pkg;

	localparam int MAX_GLYPHS_DEF = 4096;

	// Request kinds.
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	// Register file.
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam logic [1:0] REG_LOWEST  = 2'd0;
	localparam logic [1:0] REG_HIGHEST = 2'd1;
	localparam logic [1:0] REG_COUNT   = 2'd2;

	localparam logic [15:0] LOWEST_RST  = 16'h0020;
	localparam logic [15:0] HIGHEST_RST = 16'h9fa0;
	localparam logic [12:0] COUNT_RST   = 13'd3851;

	typedef struct packed {
		logic              req_type;
		logic [11:0]       entry_index;
		logic [15:0]       code_point;
		logic [11:0]       load_advance;
		logic [7:0]        load_box_width;
		logic [7:0]        load_box_height;
		logic signed [7:0] load_offset_x;
		logic signed [7:0] load_offset_y;
		logic [19:0]       load_bitmap_start;
	} req_t;

	typedef struct packed {
		logic              found;
		logic [11:0]       glyph_index;
		logic [11:0]       advance;
		logic [7:0]        box_width;
		logic [7:0]        box_height;
		logic signed [7:0] offset_x;
		logic signed [7:0] offset_y;
		logic [19:0]       bitmap_start;
	} rsp_t;

	// One descriptor table entry, 64 bits.
	typedef struct packed {
		logic [11:0] advance;
		logic [7:0]  box_width;
		logic [7:0]  box_height;
		logic [7:0]  offset_x;
		logic [7:0]  offset_y;
		logic [19:0] bitmap_start;
	} desc_t;

	typedef struct packed {
		logic [15:0] lowest_code;
		logic [15:0] highest_code;
		logic [12:0] glyph_count;
	} cfg_t;

	// Controller to datapath.
	typedef struct packed {
		logic accept;
		logic load;
		logic start;
		logic step;
		logic take_hit;
		logic take_miss;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic in_range;
		logic hit;
		logic more;
	} sts_t;

endpackage

/* rtl/core/gbsl_regs.sv */
`timescale 1ns / 1ps
// Configuration registers of the glyph lookup engine behind an APB-style port.
// Depends on gbsl_pkg.
module gbsl_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [gbsl_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [gbsl_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [gbsl_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	output gbsl_pkg::cfg_t                    cfg
);
	import gbsl_pkg::*;

	logic       wr_en;
	logic [1:0] reg_idx;
	cfg_t       cfg_q;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lowest_code  <= LOWEST_RST;
			cfg_q.highest_code <= HIGHEST_RST;
			cfg_q.glyph_count  <= COUNT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_LOWEST:  cfg_q.lowest_code  <= pwdata[15:0];
				REG_HIGHEST: cfg_q.highest_code <= pwdata[15:0];
				REG_COUNT:   cfg_q.glyph_count  <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_LOWEST:  prdata = APB_DATA_W'(cfg_q.lowest_code);
			REG_HIGHEST: prdata = APB_DATA_W'(cfg_q.highest_code);
			REG_COUNT:   prdata = APB_DATA_W'(cfg_q.glyph_count);
			default:     prdata = '0;
		endcase
	end

endmodule

/* rtl/core/gbsl_ctrl.sv */
`timescale 1ns / 1ps
// Sequencing state machine of the glyph lookup engine: handshakes and search steps.
// Depends on gbsl_pkg; drives the datapath through cmd_t and reads sts_t.
module gbsl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_type,
	output logic           req_stall,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	input  gbsl_pkg::sts_t sts,
	output gbsl_pkg::cmd_t cmd
);
	import gbsl_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_MISS   = 2'd2;

	logic [1:0] state_q, state_nxt;
	logic       rsp_valid_q;
	logic       accept;
	logic       out_free;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && (state_q == S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd        = '0;
		state_nxt  = state_q;
		cmd.accept = accept;
		cmd.load   = accept && (req_type == REQ_LOAD);
		case (state_q)
			S_IDLE: begin
				if (accept && (req_type == REQ_LOOKUP)) begin
					if (sts.in_range) begin
						cmd.start = 1'b1;
						state_nxt = S_SEARCH;
					end else begin
						state_nxt = S_MISS;
					end
				end
			end
			S_SEARCH: begin
				// A finished search waits here while the output register holds a stalled response.
				if (sts.hit) begin
					if (out_free) begin
						cmd.take_hit = 1'b1;
						state_nxt    = S_IDLE;
					end
				end else if (sts.more) begin
					cmd.step = 1'b1;
				end else if (out_free) begin
					cmd.take_miss = 1'b1;
					state_nxt     = S_IDLE;
				end
			end
			S_MISS: begin
				if (out_free) begin
					cmd.take_miss = 1'b1;
					state_nxt     = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.take_hit || cmd.take_miss) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == S_SEARCH) || ($past(state_q) == S_MISS))
		else $error("result appeared without a lookup in progress");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |-> !(cmd.take_hit || cmd.take_miss))
		else $error("waiting result overwritten");

	a_step_stays: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> (state_q == S_SEARCH))
		else $error("search left after a step");

endmodule

/* rtl/core/gbsl_dp.sv */
`timescale 1ns / 1ps
// Datapath of the glyph lookup engine: code and descriptor tables, search bounds,
// probe compare and the result register. Depends on gbsl_pkg.
module gbsl_dp #(
	parameter int MAX_GLYPHS = gbsl_pkg::MAX_GLYPHS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  gbsl_pkg::req_t req,
	input  gbsl_pkg::cfg_t cfg,
	input  gbsl_pkg::cmd_t cmd,
	output gbsl_pkg::sts_t sts,
	output gbsl_pkg::rsp_t rsp
);
	import gbsl_pkg::*;

	localparam int IW = $clog2(MAX_GLYPHS);
	localparam int NW = $clog2(MAX_GLYPHS + 1);

	logic [15:0] code_mem [MAX_GLYPHS];
	desc_t       desc_mem [MAX_GLYPHS];

	logic [15:0]   code_rd_q;
	desc_t         desc_rd_q;
	logic [15:0]   key_q;
	logic [NW-1:0] lo_q, hi1_q;
	logic [IW-1:0] mid_q;
	logic [NW-1:0] n_lim, nxt_lo, nxt_hi1;
	logic [NW:0]   init_sum, nxt_sum;
	logic [IW-1:0] mid_init, mid_nxt, rd_addr;
	logic          rd_en, key_lt, load_ok;
	desc_t         load_desc;
	rsp_t          rsp_q;

	// The search span is [lo, hi1), hi1 being one past the last candidate.
	always_comb begin
		if (32'(cfg.glyph_count) > 32'(MAX_GLYPHS)) begin
			n_lim = NW'(MAX_GLYPHS);
		end else begin
			n_lim = NW'(cfg.glyph_count);
		end
	end

	assign init_sum = {1'b0, n_lim} - (NW+1)'(1);
	assign mid_init = IW'(init_sum >> 1);

	assign key_lt  = key_q < code_rd_q;
	assign nxt_lo  = key_lt ? lo_q : NW'(mid_q) + NW'(1);
	assign nxt_hi1 = key_lt ? NW'(mid_q) : hi1_q;
	assign nxt_sum = {1'b0, nxt_lo} + {1'b0, nxt_hi1} - (NW+1)'(1);
	assign mid_nxt = IW'(nxt_sum >> 1);

	assign sts.in_range = (req.code_point >= cfg.lowest_code)
		&& (req.code_point <= cfg.highest_code) && (n_lim != '0);
	assign sts.hit  = (key_q == code_rd_q);
	assign sts.more = (nxt_lo < nxt_hi1);

	assign rd_en   = cmd.start || cmd.step;
	assign rd_addr = cmd.start ? mid_init : mid_nxt;
	assign load_ok = 32'(req.entry_index) < 32'(MAX_GLYPHS);

	assign load_desc.advance      = req.load_advance;
	assign load_desc.box_width    = req.load_box_width;
	assign load_desc.box_height   = req.load_box_height;
	assign load_desc.offset_x     = req.load_offset_x;
	assign load_desc.offset_y     = req.load_offset_y;
	assign load_desc.bitmap_start = req.load_bitmap_start;

	// Both tables are read at the probe address, so the descriptor is ready on a match.
	always_ff @(posedge clk) begin
		if (cmd.load && load_ok) begin
			code_mem[IW'(req.entry_index)] <= req.code_point;
			desc_mem[IW'(req.entry_index)] <= load_desc;
		end
		if (rd_en) begin
			code_rd_q <= code_mem[rd_addr];
			desc_rd_q <= desc_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q <= req.code_point;
		end
		if (cmd.start) begin
			lo_q  <= '0;
			hi1_q <= n_lim;
			mid_q <= mid_init;
		end else if (cmd.step) begin
			lo_q  <= nxt_lo;
			hi1_q <= nxt_hi1;
			mid_q <= mid_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_hit) begin
			rsp_q.found        <= 1'b1;
			rsp_q.glyph_index  <= 12'(mid_q);
			rsp_q.advance      <= desc_rd_q.advance;
			rsp_q.box_width    <= desc_rd_q.box_width;
			rsp_q.box_height   <= desc_rd_q.box_height;
			rsp_q.offset_x     <= desc_rd_q.offset_x;
			rsp_q.offset_y     <= desc_rd_q.offset_y;
			rsp_q.bitmap_start <= desc_rd_q.bitmap_start;
		end else if (cmd.take_miss) begin
			rsp_q <= '0;
		end
	end

	assign rsp = rsp_q;

	a_span_open: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> (lo_q < hi1_q))
		else $error("search step left an empty span");

	a_mid_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> (NW'(mid_q) >= lo_q) && (NW'(mid_q) < hi1_q))
		else $error("probe outside the search span");

	a_start_span: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (lo_q == '0) && (NW'(mid_q) < hi1_q))
		else $error("bad initial search span");

endmodule

/* rtl/core/glyph_binary_search_lookup_core.sv */
`timescale 1ns / 1ps
// Glyph lookup engine top level: register block, controller and datapath.
// Depends on gbsl_pkg, gbsl_regs, gbsl_ctrl and gbsl_dp.
//
// Requests arrive on req (valid/stall); a load writes one code point and its
// descriptor into the tables and gives no response. A lookup gives exactly one
// response on rsp (valid/stall): found, glyph index and descriptor, or all zero.
// Loads are taken one per cycle while no lookup is in progress. A lookup runs a
// binary search that does one table read and compare per cycle: an in-range code
// point takes at most ceil(log2(n+1)) probes for n searched entries (13 for 4096),
// and its response is registered after the last probe, once the output slot is free.
// An out-of-range code point, or a zero glyph count, is answered without a search
// through the miss state. req_stall is high from acceptance of a lookup until its
// response is written. The response sits in an output register; while the receiver
// stalls it, the next request may still be accepted, and a new response waits for
// the slot. Reset clears the handshake state and loads the register reset values;
// the tables are not cleared and an entry must be loaded before it is searched.
// Configuration lives on the APB-style port; the user must write it only while the
// block is idle, and the block itself does not enforce this.
module glyph_binary_search_lookup_core #(
	parameter int MAX_GLYPHS = gbsl_pkg::MAX_GLYPHS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  gbsl_pkg::req_t                  req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output gbsl_pkg::rsp_t                  rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [gbsl_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [gbsl_pkg::APB_DATA_W-1:0] pwdata,
	output logic [gbsl_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);
	import gbsl_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	gbsl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gbsl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	gbsl_dp #(
		.MAX_GLYPHS (MAX_GLYPHS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the glyph lookup engine: table loads, lookups and APB settings.
// Depends on gbsl_pkg and glyph_binary_search_lookup_core; needs no other file.
module tb_top;
	import gbsl_pkg::*;

	localparam int GLYPHS       = MAX_GLYPHS_DEF;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 300;
	localparam int LIMIT        = 400000;
	localparam int PHASE_ITEMS  = 30;
	localparam int DEEP_ITEMS   = 6;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		req_t        item;
		bit          miss;
		logic [1:0]  reg_sel;
		logic [31:0] reg_val;
	} row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	req_t                  req       = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	rsp_t                  rsp;
	logic                  psel      = 1'b0;
	logic                  penable   = 1'b0;
	logic                  pwrite    = 1'b0;
	logic [APB_ADDR_W-1:0] paddr     = '0;
	logic [APB_DATA_W-1:0] pwdata    = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// Shadow of the lookup state, updated as each transaction is accepted.
	logic [15:0] lo_code   = LOWEST_RST;
	logic [15:0] hi_code   = HIGHEST_RST;
	logic [12:0] glyph_cnt = COUNT_RST;
	logic [15:0] code_tbl [GLYPHS];
	desc_t       desc_tbl [GLYPHS];
	bit          written  [GLYPHS];

	rsp_t answer_q [$];
	int   fail_count  = 0;
	int   cycle_count = 0;
	int   idle_mode   = 0;
	bit   hold_req    = 1'b0;
	bit   hold_seen   = 1'b0;
	int   hold_left   = 0;

	glyph_binary_search_lookup_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// Binary search over the shadow tables. blank flags a probe of an entry never loaded.
	function automatic rsp_t search_glyph(input logic [15:0] cp, output bit blank);
		rsp_t r;
		int   span;
		int   lo;
		int   hi;
		int   mid;
		r = '0;
		blank = 1'b0;
		if (cp < lo_code || cp > hi_code)
			return r;
		span = (glyph_cnt > GLYPHS) ? GLYPHS : int'(glyph_cnt);
		lo = 0;
		hi = span - 1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (!written[mid])
				blank = 1'b1;
			if (cp < code_tbl[mid]) begin
				hi = mid - 1;
			end else if (cp > code_tbl[mid]) begin
				lo = mid + 1;
			end else begin
				r.found        = 1'b1;
				r.glyph_index  = mid[11:0];
				r.advance      = desc_tbl[mid].advance;
				r.box_width    = desc_tbl[mid].box_width;
				r.box_height   = desc_tbl[mid].box_height;
				r.offset_x     = desc_tbl[mid].offset_x;
				r.offset_y     = desc_tbl[mid].offset_y;
				r.bitmap_start = desc_tbl[mid].bitmap_start;
				return r;
			end
		end
		return r;
	endfunction

	function automatic void absorb_req(input req_t it, input bit typed_miss);
		desc_t d;
		rsp_t  want;
		bit    blank;
		if (it.req_type == REQ_LOAD) begin
			d.advance      = it.load_advance;
			d.box_width    = it.load_box_width;
			d.box_height   = it.load_box_height;
			d.offset_x     = it.load_offset_x;
			d.offset_y     = it.load_offset_y;
			d.bitmap_start = it.load_bitmap_start;
			code_tbl[it.entry_index] = it.code_point;
			desc_tbl[it.entry_index] = d;
			written[it.entry_index]  = 1'b1;
		end else begin
			want = '0;
			if (!typed_miss)
				want = search_glyph(it.code_point, blank);
			answer_q.push_back(want);
		end
	endfunction

	function automatic req_t random_req();
		logic [95:0] noise;
		noise = {$urandom(), $urandom(), $urandom()};
		return noise[92:0];
	endfunction

	function automatic row_t load_row(input int idx, input int cp, input int adv, input int bw,
			input int bh, input int ox, input int oy, input int bm);
		row_t r;
		r = '{kind: ROW_REQ, item: '0, miss: 1'b0, reg_sel: '0, reg_val: '0};
		r.item.req_type          = REQ_LOAD;
		r.item.entry_index       = 12'(idx);
		r.item.code_point        = 16'(cp);
		r.item.load_advance      = 12'(adv);
		r.item.load_box_width    = 8'(bw);
		r.item.load_box_height   = 8'(bh);
		r.item.load_offset_x     = 8'(ox);
		r.item.load_offset_y     = 8'(oy);
		r.item.load_bitmap_start = 20'(bm);
		return r;
	endfunction

	function automatic row_t look_row(input int cp, input bit miss);
		row_t r;
		r = '{kind: ROW_REQ, item: '0, miss: miss, reg_sel: '0, reg_val: '0};
		r.item.req_type   = REQ_LOOKUP;
		r.item.code_point = 16'(cp);
		return r;
	endfunction

	function automatic row_t cfg_row(input logic [1:0] sel, input int val);
		row_t r;
		r = '{kind: ROW_CFG, item: '0, miss: 1'b0, reg_sel: sel, reg_val: val};
		return r;
	endfunction

	function automatic void check_field(input string label, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: rsp.%s expected %0h, got %0h", $time, label, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (answer_q.size() == 0) begin
				$display("%0t: response with nothing expected, got %h", $time, rsp);
				fail_count++;
			end else begin
				want = answer_q.pop_front();
				check_field("found", 32'(want.found), 32'(rsp.found));
				check_field("glyph_index", 32'(want.glyph_index), 32'(rsp.glyph_index));
				check_field("advance", 32'(want.advance), 32'(rsp.advance));
				check_field("box_width", 32'(want.box_width), 32'(rsp.box_width));
				check_field("box_height", 32'(want.box_height), 32'(rsp.box_height));
				check_field("offset_x", 32'(want.offset_x), 32'(rsp.offset_x));
				check_field("offset_y", 32'(want.offset_y), 32'(rsp.offset_y));
				check_field("bitmap_start", 32'(want.bitmap_start), 32'(rsp.bitmap_start));
			end
		end
	end

	// Response side: random stalls, or a long counted hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < ((idle_mode == 0) ? 45 : (idle_mode == 1) ? 32 : 0));
		end
	end

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_req(input req_t it, input bit typed_miss);
		int gap_pct;
		gap_pct = (idle_mode == 0) ? 32 : (idle_mode == 1) ? 45 : 0;
		while ($urandom_range(99) < gap_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= it;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		absorb_req(it, typed_miss);
		@(negedge clk);
	endtask

	// Loads leave no response behind, so give the engine time to finish after the queue drains.
	task automatic settle();
		req_valid <= 1'b0;
		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] sel, input logic [31:0] val);
		logic [31:0] got;
		paddr   <= APB_ADDR_W'({sel, 2'b00});
		pwdata  <= val;
		pwrite  <= 1'b1;
		psel    <= 1'b1;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		got = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== val) begin
			$display("%0t: register %0d read expected %0h, got %0h", $time, sel, val, got);
			fail_count++;
		end
		case (sel)
			REG_LOWEST: begin
				lo_code = val[15:0];
			end
			REG_HIGHEST: begin
				hi_code = val[15:0];
			end
			REG_COUNT: begin
				glyph_cnt = val[12:0];
			end
			default: begin
			end
		endcase
	endtask

	// Strictly ascending code points at entries 0 .. k-1, descriptors random.
	task automatic load_sorted(input int k);
		req_t it;
		int   step_max;
		int   cp;
		int   i;
		step_max = 65535 / k;
		cp = $urandom_range(0, step_max - 1);
		for (i = 0; i < k; i++) begin
			it = random_req();
			it.req_type    = REQ_LOAD;
			it.entry_index = 12'(i);
			it.code_point  = 16'(cp);
			send_req(it, 1'b0);
			cp += 1 + $urandom_range(0, step_max - 2);
		end
	endtask

	task automatic random_item(input int k);
		req_t it;
		rsp_t probe;
		bit   blank;
		int   pick;
		it = random_req();
		pick = $urandom_range(99);
		if (pick < 65) begin
			it.req_type   = REQ_LOOKUP;
			it.code_point = code_tbl[$urandom_range(0, k - 1)];
		end else if (pick < 85) begin
			it.req_type = REQ_LOOKUP;
		end else begin
			it.req_type = REQ_LOAD;
			if ($urandom_range(9) < 7)
				it.entry_index = 12'($urandom_range(0, k - 1));
		end
		if (it.req_type == REQ_LOOKUP) begin
			probe = search_glyph(it.code_point, blank);
			// Never let a search touch an entry that was not loaded.
			if (blank)
				it.req_type = REQ_LOAD;
		end
		send_req(it, 1'b0);
	endtask

	// Loads every unloaded entry on the probe path of a random key, then looks the key up.
	task automatic deep_item();
		req_t        it;
		logic [15:0] key;
		int          span;
		int          lo;
		int          hi;
		int          mid;
		bit          done;
		key  = 16'($urandom());
		span = (glyph_cnt > GLYPHS) ? GLYPHS : int'(glyph_cnt);
		lo   = 0;
		hi   = span - 1;
		done = 1'b0;
		while (!done && lo <= hi) begin
			mid = (lo + hi) / 2;
			if (!written[mid]) begin
				it             = random_req();
				it.req_type    = REQ_LOAD;
				it.entry_index = mid[11:0];
				// Now and then plant the key so that the search ends at this depth.
				if ($urandom_range(19) == 0)
					it.code_point = key;
				else if (it.code_point == key)
					it.code_point = ~key;
				send_req(it, 1'b0);
			end
			if (key < code_tbl[mid])
				hi = mid - 1;
			else if (key > code_tbl[mid])
				lo = mid + 1;
			else
				done = 1'b1;
		end
		it            = random_req();
		it.req_type   = REQ_LOOKUP;
		it.code_point = key;
		send_req(it, 1'b0);
	endtask

	initial begin
		row_t        plan [$];
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] cnt;
		int          ph;
		int          n;
		int          k;
		bit          deep;

		// Out-of-range lookups under the reset settings never search the table.
		plan.push_back(look_row(16'h0000, 1'b1));
		plan.push_back(look_row(16'h001f, 1'b1));
		plan.push_back(look_row(16'h9fa1, 1'b1));
		plan.push_back(look_row(16'hffff, 1'b1));
		plan.push_back(load_row(0, 16'h0000, 0, 0, 0, 0, 0, 0));
		plan.push_back(load_row(1, 16'h0020, 12'hfff, 8'hff, 8'hff, 127, 127, 20'hfffff));
		plan.push_back(load_row(2, 16'h8000, 12'h555, 8'haa, 8'h55, -128, -128, 20'haaaaa));
		plan.push_back(load_row(3, 16'hffff, 12'haaa, 8'h55, 8'haa, -1, 0, 20'h55555));
		plan.push_back(load_row(4095, 16'h7fff, 1, 1, 1, 1, -1, 1));
		plan.push_back(cfg_row(REG_COUNT, 4));
		plan.push_back(look_row(16'h0020, 1'b0));
		plan.push_back(look_row(16'h0000, 1'b1));
		plan.push_back(cfg_row(REG_LOWEST, 16'h0000));
		plan.push_back(cfg_row(REG_HIGHEST, 16'hffff));
		plan.push_back(look_row(16'h0000, 1'b0));
		plan.push_back(look_row(16'hffff, 1'b0));
		plan.push_back(look_row(16'h8000, 1'b0));
		plan.push_back(look_row(16'h1234, 1'b1));
		plan.push_back(cfg_row(REG_LOWEST, 16'hffff));
		plan.push_back(look_row(16'hffff, 1'b0));
		plan.push_back(look_row(16'hfffe, 1'b1));
		// Lowest above highest: nothing is in range.
		plan.push_back(cfg_row(REG_LOWEST, 16'h9000));
		plan.push_back(cfg_row(REG_HIGHEST, 16'h1000));
		plan.push_back(look_row(16'h8000, 1'b1));
		plan.push_back(look_row(16'h9000, 1'b1));
		// Break the ordering; the search follows the same probes regardless.
		plan.push_back(load_row(2, 16'h0010, 12'h800, 8'h80, 8'h01, 64, -64, 20'h80000));
		plan.push_back(cfg_row(REG_LOWEST, 16'h0000));
		plan.push_back(cfg_row(REG_HIGHEST, 16'hffff));
		plan.push_back(look_row(16'h0010, 1'b0));
		plan.push_back(cfg_row(REG_COUNT, 0));
		plan.push_back(look_row(16'h0020, 1'b1));
		plan.push_back(cfg_row(REG_COUNT, 1));
		plan.push_back(look_row(16'h0000, 1'b0));
		plan.push_back(look_row(16'h0020, 1'b1));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				settle();
				write_reg(plan[i].reg_sel, plan[i].reg_val);
			end else begin
				send_req(plan[i].item, plan[i].miss);
			end
		end
		settle();

		k = 2;
		for (ph = 0; ph < 9; ph++) begin
			idle_mode = ph / 3;
			deep = (ph == 4) || (ph == 5);
			if (!deep) begin
				k = $urandom_range(2, 24);
				load_sorted(k);
			end
			settle();
			lo  = 32'h0000;
			hi  = 32'hffff;
			cnt = k;
			if (ph == 4) begin
				// Search over the whole capacity; path entries are loaded on demand.
				cnt = GLYPHS;
			end else if (ph == 5) begin
				// A count above capacity is clamped.
				cnt = 8191;
			end else if (ph == 7) begin
				lo = 32'(code_tbl[k / 2]);
				hi = lo;
			end else begin
				if ($urandom_range(1))
					lo = $urandom_range(0, code_tbl[k / 4]);
				if ($urandom_range(1))
					hi = $urandom_range(code_tbl[(3 * k) / 4], 16'hffff);
				if ($urandom_range(9) < 3)
					cnt = $urandom_range(0, k);
			end
			write_reg(REG_LOWEST, lo);
			write_reg(REG_HIGHEST, hi);
			write_reg(REG_COUNT, cnt);
			for (n = 0; n < (deep ? DEEP_ITEMS : PHASE_ITEMS); n++) begin
				if (ph == 1 && n == 4)
					hold_req <= ~hold_req;
				if (ph == 7 && n == 20) begin
					req_valid <= 1'b0;
					while (answer_q.size() != 0)
						@(posedge clk);
					@(negedge clk);
				end
				if (deep)
					deep_item();
				else
					random_item(k);
			end
			settle();
		end

		if (fail_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

/* glyph_binary_search_lookup_core.f */
rtl/core/gbsl_pkg.sv
rtl/core/gbsl_regs.sv
rtl/core/gbsl_ctrl.sv
rtl/core/gbsl_dp.sv
rtl/core/glyph_binary_search_lookup_core.sv
tb/sv/tb_top.sv
